### src/dtq_pkg.sv
// Package for the drop-tail transmit queue.
// Holds field widths, operation codes and the controller-to-datapath command struct.
// Depends on nothing.
`default_nettype none

package dtq_pkg;

   // Fixed field widths.
   localparam int ID_W    = 32;
   localparam int COUNT_W = 7;
   localparam int TOTAL_W = 32;

   // Reset value of the queue limit register.
   localparam logic [COUNT_W-1:0] LIMIT_RESET = 7'd64;

   // Request operation codes.
   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_FINISH  = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // take the request fields and read the queue head
      logic execute;   // update the queue and load the response
   } dtq_cmd_type;

endpackage

`default_nettype wire

### src/dtq_ctrl.sv
// Controller state machine of the drop-tail transmit queue.
// Sequences capture, execute and response hand-off; uses dtq_pkg.
`default_nettype none

module dtq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dtq_pkg::dtq_cmd_type cmd
);
   import dtq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Handshake outputs and datapath commands.
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = (state_ff == ST_RESP);
   assign cmd.capture = (state_ff == ST_IDLE) && req_valid;
   assign cmd.execute = (state_ff == ST_EXEC);

endmodule

`default_nettype wire

### src/dtq_datapath.sv
// Datapath of the drop-tail transmit queue: packet store, pointers, fill count,
// transmitter flag, saturating counters, limit register and response fields; uses dtq_pkg.
`default_nettype none

module dtq_datapath #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dtq_pkg::dtq_cmd_type          cmd,
   input  logic                          req_operation,
   input  logic [dtq_pkg::ID_W-1:0]      req_packet_id,
   input  logic                          csr_write_enable,
   input  logic [dtq_pkg::COUNT_W-1:0]   csr_write_data,
   output logic                          rsp_send_valid,
   output logic [dtq_pkg::ID_W-1:0]      rsp_sent_packet,
   output logic                          rsp_dropped,
   output logic [dtq_pkg::COUNT_W-1:0]   rsp_queue_length,
   output logic                          rsp_transmitter_busy,
   output logic [dtq_pkg::TOTAL_W-1:0]   rsp_arrived_total,
   output logic [dtq_pkg::TOTAL_W-1:0]   rsp_dropped_total
);
   import dtq_pkg::*;

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PtrW-1:0] LAST_SLOT = PtrW'(QUEUE_DEPTH - 1);

   logic [ID_W-1:0]    store_mem [QUEUE_DEPTH];
   logic [ID_W-1:0]    head_data_ff;
   logic               op_ff;
   logic [ID_W-1:0]    pkt_ff;

   logic [PtrW-1:0]    head_ff, head_in;
   logic [PtrW-1:0]    tail_ff, tail_in;
   logic [COUNT_W-1:0] fill_ff, fill_in;
   logic               busy_ff, busy_in;
   logic [TOTAL_W-1:0] arrived_ff, arrived_in;
   logic [TOTAL_W-1:0] drops_ff, drops_in;
   logic [COUNT_W-1:0] limit_ff;

   logic               send_ff, send_in;
   logic [ID_W-1:0]    sent_ff, sent_in;
   logic               drop_ff, drop_in;

   logic               queue_full;
   logic               push;

   // The queue is full at the configured limit or at the store depth.
   assign queue_full = (fill_ff >= limit_ff) || (32'(fill_ff) >= 32'(QUEUE_DEPTH));

   // Queue update for one request.
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      fill_in    = fill_ff;
      busy_in    = busy_ff;
      arrived_in = arrived_ff;
      drops_in   = drops_ff;
      send_in    = 1'b0;
      sent_in    = '0;
      drop_in    = 1'b0;
      push       = 1'b0;
      case (op_ff)
         OP_ARRIVAL: begin
            arrived_in = (arrived_ff == '1) ? arrived_ff : arrived_ff + 1'b1;
            if (!busy_ff) begin
               send_in = 1'b1;
               sent_in = pkt_ff;
               busy_in = 1'b1;
            end else if (!queue_full) begin
               push    = 1'b1;
               tail_in = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
               fill_in = fill_ff + 1'b1;
            end else begin
               drop_in  = 1'b1;
               drops_in = (drops_ff == '1) ? drops_ff : drops_ff + 1'b1;
            end
         end
         OP_FINISH: begin
            if (fill_ff != '0) begin
               send_in = 1'b1;
               sent_in = head_data_ff;
               head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
               fill_in = fill_ff - 1'b1;
               busy_in = 1'b1;
            end else begin
               busy_in = 1'b0;
            end
         end
         default: begin
            busy_in = busy_ff;
         end
      endcase
   end

   // Packet store: written at the tail, head read registered at capture.
   always_ff @(posedge clock) begin
      if (cmd.execute && push) begin
         store_mem[tail_ff] <= pkt_ff;
      end
      if (cmd.capture) begin
         head_data_ff <= store_mem[head_ff];
      end
   end

   // Request holding registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_operation;
         pkt_ff <= req_packet_id;
      end
   end

   // Response payload registers.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         send_ff <= send_in;
         sent_ff <= sent_in;
         drop_ff <= drop_in;
      end
   end

   // Queue state, counters and limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         fill_ff    <= '0;
         busy_ff    <= 1'b0;
         arrived_ff <= '0;
         drops_ff   <= '0;
         limit_ff   <= LIMIT_RESET;
      end else begin
         if (cmd.execute) begin
            head_ff    <= head_in;
            tail_ff    <= tail_in;
            fill_ff    <= fill_in;
            busy_ff    <= busy_in;
            arrived_ff <= arrived_in;
            drops_ff   <= drops_in;
         end
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
      end
   end

   // State does not move between execute and hand-off, so it is shown directly.
   assign rsp_send_valid       = send_ff;
   assign rsp_sent_packet      = sent_ff;
   assign rsp_dropped          = drop_ff;
   assign rsp_queue_length     = fill_ff;
   assign rsp_transmitter_busy = busy_ff;
   assign rsp_arrived_total    = arrived_ff;
   assign rsp_dropped_total    = drops_ff;

endmodule

`default_nettype wire

### src/drop_tail_transmit_queue.sv
// Top level of the drop-tail transmit queue.
// Joins dtq_ctrl and dtq_datapath; uses dtq_pkg.
//
//   Channel   Ports             Direction   Content
//   request   req_*             in          operation, packet handle
//   response  rsp_*             out         send, drop, fill, busy, totals
//   register  csr_*             in          queue limit, written without wait
//
// Each request passes through capture together with the registered read of
// the queue head, the queue update, and the response. The next request is
// taken in the cycle after the response is accepted, so only one request is
// in flight at a time.
// Reset is synchronous; the packet store is not cleared and needs no sweep.
// A stalled response holds, and requests stall until it leaves.
`default_nettype none

module drop_tail_transmit_queue #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [dtq_pkg::ID_W-1:0]      req_packet_id,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_send_valid,
   output logic [dtq_pkg::ID_W-1:0]      rsp_sent_packet,
   output logic                          rsp_dropped,
   output logic [dtq_pkg::COUNT_W-1:0]   rsp_queue_length,
   output logic                          rsp_transmitter_busy,
   output logic [dtq_pkg::TOTAL_W-1:0]   rsp_arrived_total,
   output logic [dtq_pkg::TOTAL_W-1:0]   rsp_dropped_total,
   input  logic                          csr_write_enable,
   input  logic [dtq_pkg::COUNT_W-1:0]   csr_write_data
);
   import dtq_pkg::*;

   dtq_cmd_type cmd;

   // Sequencing of each request.
   dtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Queue storage and arithmetic.
   dtq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_operation        (req_operation),
      .req_packet_id        (req_packet_id),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .rsp_send_valid       (rsp_send_valid),
      .rsp_sent_packet      (rsp_sent_packet),
      .rsp_dropped          (rsp_dropped),
      .rsp_queue_length     (rsp_queue_length),
      .rsp_transmitter_busy (rsp_transmitter_busy),
      .rsp_arrived_total    (rsp_arrived_total),
      .rsp_dropped_total    (rsp_dropped_total)
   );

   // A request is never both sent and dropped.
   a_send_xor_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_send_valid && rsp_dropped))
      else $error("request reported as both sent and dropped");

   // Packets wait only while the transmitter is busy.
   a_wait_needs_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_queue_length != '0)) |-> rsp_transmitter_busy)
      else $error("packets queued while transmitter idle");

   // The queue never holds more than the store depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_queue_length) <= 32'(QUEUE_DEPTH)))
      else $error("queue fill beyond store depth");

   // An accepted request is followed by a stall while it executes.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (req_stall && !rsp_valid))
      else $error("second request taken while one is in flight");

endmodule

`default_nettype wire
